/* rtl/core/lru_key_value_cache_defines.svh */
// assertion macros shared by the cache rtl
// depends on clk and arst_n being visible in the using module
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LKVC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define LKVC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/lkvc_pkg.sv */
// shared types and constants of the lru key/value cache
// no dependencies
package lkvc_pkg;
	localparam int DEPTH_DEF = 16;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef struct packed {
		logic req_type;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [VAL_W-1:0] read_value;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic exec;
	} cmd_t;
endpackage

/* rtl/core/lkvc_datapath.sv */
// key store, value store, recency ranks and result register
// depends on lkvc_pkg
module lkvc_datapath #(
	parameter int DEPTH = lkvc_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  lkvc_pkg::cmd_t cmd,
	input  lkvc_pkg::req_t req,
	input  logic cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata,
	output lkvc_pkg::rsp_t rsp
);
	import lkvc_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int CW = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	logic [KEY_W-1:0] keys_q [DEPTH];
	logic [VAL_W-1:0] values_q [DEPTH];
	logic [IDX_W-1:0] age_q [DEPTH];
	logic [OCC_W-1:0] occ_q;
	logic [CAP_W-1:0] cap_q;
	req_t req_q;
	rsp_t rsp_q;

	logic [DEPTH-1:0] match, victim;
	logic hit, full, is_write;
	logic [IDX_W-1:0] hit_idx, vic_idx, sel_idx, pos;
	logic [OCC_W-1:0] target;
	logic [CW-1:0] eff_cap;

	always_comb begin
		if (cap_q == '0)
			eff_cap = CW'(1);
		else if (CW'(cap_q) > CW'(DEPTH))
			eff_cap = CW'(DEPTH);
		else
			eff_cap = CW'(cap_q);
	end

	always_comb begin
		is_write = (req_q.req_type == REQ_WRITE);
		full = (CW'(occ_q) >= eff_cap);
		target = full ? (occ_q - OCC_W'(1)) : occ_q;
		hit_idx = '0;
		vic_idx = '0;
		for (int s = 0; s < DEPTH; s++) begin
			match[s] = (OCC_W'(age_q[s]) < occ_q) && (keys_q[s] == req_q.key);
			victim[s] = (OCC_W'(age_q[s]) == target);
			if (match[s])
				hit_idx = hit_idx | IDX_W'(s);
			if (victim[s])
				vic_idx = vic_idx | IDX_W'(s);
		end
		hit = |match;
		sel_idx = hit ? hit_idx : vic_idx;
		pos = hit ? age_q[hit_idx] : target[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			cap_q <= CAP_RESET;
			for (int s = 0; s < DEPTH; s++)
				age_q[s] <= IDX_W'(s);
		end else begin
			if (cfg_we)
				cap_q <= cfg_wdata;
			if (cmd.exec && (hit || is_write)) begin
				for (int s = 0; s < DEPTH; s++) begin
					if (IDX_W'(s) == sel_idx)
						age_q[s] <= '0;
					else if (age_q[s] < pos)
						age_q[s] <= age_q[s] + IDX_W'(1);
				end
				if (!hit && !full)
					occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			req_q <= req;
		if (cmd.exec) begin
			if (is_write) begin
				values_q[sel_idx] <= req_q.value;
				if (!hit)
					keys_q[sel_idx] <= req_q.key;
			end
			rsp_q.hit <= hit;
			rsp_q.read_value <= (hit && !is_write) ? values_q[hit_idx] : '0;
		end
	end

	assign rsp = rsp_q;
endmodule

/* rtl/core/lkvc_ctrl.sv */
// request sequencer and output handshake of the cache
// depends on lkvc_pkg and the assertion macro header
module lkvc_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output lkvc_pkg::cmd_t cmd
);
	import lkvc_pkg::*;
	`include "lru_key_value_cache_defines.svh"

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q == ST_EXEC);
	assign cmd.load = (state_q == ST_IDLE) && in_valid;
	assign cmd.exec = (state_q == ST_EXEC) && out_free;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cmd.exec)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	`LKVC_ASSERT_NEXT(a_load_to_exec, cmd.load, state_q == ST_EXEC)
	`LKVC_ASSERT_NEXT(a_exec_gives_out, cmd.exec, out_valid_q && state_q == ST_IDLE)
	`LKVC_ASSERT_NOW(a_no_exec_over_held, out_valid_q && out_stall, !cmd.exec)
endmodule

/* rtl/core/lru_key_value_cache.sv */
// fully associative key/value cache with lru replacement, top level
// result: registered in the compare-and-update step that follows the capture step
// one request at a time: in_stall holds a new one off until the compare-and-update step
// a stalled result holds the captured request until the output register frees up
// reset: occupancy zero, identity recency order, capacity 16, no result pending
// depends on lkvc_pkg, lkvc_ctrl, lkvc_datapath
module lru_key_value_cache #(
	parameter int DEPTH = lkvc_pkg::DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  lkvc_pkg::req_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output lkvc_pkg::rsp_t out_data,
	input  logic cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata
);
	import lkvc_pkg::*;

	cmd_t cmd;

	lkvc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd(cmd)
	);

	lkvc_datapath #(.DEPTH(DEPTH)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req(in_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.rsp(out_data)
	);
endmodule

/* bench/lru_key_value_cache_tb.sv */
// testbench for the lru key/value cache: directed table then random traffic
// checks every result against a behavioral lru predictor; depends on lkvc_pkg and lru_key_value_cache
`timescale 1ns / 100ps

module lru_key_value_cache_tb;
	import lkvc_pkg::*;

	localparam int DEPTH = DEPTH_DEF;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		logic cfg;
		logic [CAP_W-1:0] cap;
		req_t req;
		logic known;
		rsp_t rsp;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;
	logic cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	lru_key_value_cache #(.DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [KEY_W-1:0] slot_key [DEPTH];
	logic [VAL_W-1:0] slot_val [DEPTH];
	int order [DEPTH];
	int occ;
	logic [CAP_W-1:0] cap_reg;

	rsp_t pending_rsp [$];
	int errors = 0;
	int cycles = 0;
	int accepted = 0;
	int answered = 0;
	int hits = 0;
	int hold_cycles = 0;
	bit stim_done = 0;
	bit long_hold_req = 0;

	task automatic report(input string what, input logic [VAL_W-1:0] got, exp);
		errors++;
		$display("ERROR %0t: %s got %h expected %h", $time, what, got, exp);
	endtask

	function automatic rsp_t lru_predict(input req_t r);
		rsp_t o;
		int pos, slot, eff, i;
		bit found;
		o = '0;
		found = 0;
		slot = 0;
		for (pos = 0; pos < occ; pos++) begin
			if (slot_key[order[pos]] == r.key) begin
				found = 1;
				slot = order[pos];
				break;
			end
		end
		o.hit = found;
		eff = (cap_reg == 0) ? 1 : (cap_reg > DEPTH ? DEPTH : cap_reg);
		if (found) begin
			if (r.req_type == REQ_WRITE) slot_val[slot] = r.value;
			else o.read_value = slot_val[slot];
		end else if (r.req_type == REQ_WRITE) begin
			if (occ >= eff) begin
				pos = occ - 1;
			end else begin
				pos = occ;
				occ++;
			end
			slot = order[pos];
			slot_key[slot] = r.key;
			slot_val[slot] = r.value;
		end
		if (found || r.req_type == REQ_WRITE) begin
			for (i = pos; i > 0; i--) order[i] = order[i - 1];
			order[0] = slot;
		end
		return o;
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// result side
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && out_valid && !out_stall) begin
			answered++;
			if (pending_rsp.size() == 0) begin
				report("result with nothing pending", out_data.read_value, '0);
			end else begin
				e = pending_rsp.pop_front();
				if (out_data.hit != e.hit)
					report("hit", VAL_W'(out_data.hit), VAL_W'(e.hit));
				if (out_data.read_value != e.read_value)
					report("read_value", out_data.read_value, e.read_value);
				if (out_data.hit) hits++;
			end
		end
	end

	// receiver stall pattern
	initial begin
		int n, i;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				out_stall <= 1'b1;
				for (i = 0; i < 60; i++) begin
					@(posedge clk);
					hold_cycles++;
				end
				long_hold_req = 0;
			end
			n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			if (stim_done) n = $urandom_range(0, 2);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
		end
	end

	task automatic send(input req_t r, input logic known, input rsp_t exp_rsp, input bit idle);
		rsp_t p;
		int n;
		n = idle ? $urandom_range(0, 11) : 0;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		p = lru_predict(r);
		if (known && p.hit != exp_rsp.hit)
			report("table row hit", VAL_W'(p.hit), VAL_W'(exp_rsp.hit));
		if (known && p.read_value != exp_rsp.read_value)
			report("table row read_value", p.read_value, exp_rsp.read_value);
		pending_rsp.push_back(p);
		accepted++;
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] c);
		in_valid <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = c;
	endtask

	function automatic req_t mk(input logic t, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v);
		req_t r;
		r.req_type = t;
		r.key = k;
		r.value = v;
		return r;
	endfunction

	function automatic rsp_t rs(input logic h, input logic [VAL_W-1:0] v);
		rsp_t o;
		o.hit = h;
		o.read_value = v;
		return o;
	endfunction

	row_t dir_rows [$];

	initial begin
		int i, phase, pool, hot;
		logic [KEY_W-1:0] keys [24];
		req_t r;
		for (i = 0; i < DEPTH; i++) order[i] = i;
		occ = 0;
		cap_reg = CAP_RESET;

		dir_rows = '{
			'{0, 0, mk(REQ_LOOKUP, 32'h0, 32'hFFFF_FFFF), 1, rs(0, 0)},
			'{0, 0, mk(REQ_WRITE, 32'h0, 32'hFFFF_FFFF), 1, rs(0, 0)},
			'{0, 0, mk(REQ_LOOKUP, 32'h0, 32'h0), 1, rs(1, 32'hFFFF_FFFF)},
			'{0, 0, mk(REQ_WRITE, 32'hFFFF_FFFF, 32'h0), 1, rs(0, 0)},
			'{0, 0, mk(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h1), 1, rs(1, 0)},
			'{0, 0, mk(REQ_WRITE, 32'h0, 32'hA5A5_5A5A), 1, rs(1, 0)},
			'{0, 0, mk(REQ_LOOKUP, 32'h0, 32'h0), 1, rs(1, 32'hA5A5_5A5A)},
			'{1, 5'd2, mk(REQ_WRITE, 32'h1234, 32'h55), 0, rs(0, 0)},
			'{0, 0, mk(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0), 0, rs(0, 0)},
			'{0, 0, mk(REQ_LOOKUP, 32'h1234, 32'h0), 0, rs(0, 0)},
			'{1, 5'd0, mk(REQ_WRITE, 32'h7, 32'h77), 0, rs(0, 0)},
			'{0, 0, mk(REQ_WRITE, 32'h8, 32'h88), 0, rs(0, 0)},
			'{0, 0, mk(REQ_LOOKUP, 32'h7, 32'h0), 0, rs(0, 0)},
			'{0, 0, mk(REQ_LOOKUP, 32'h8, 32'h0), 0, rs(0, 0)},
			'{1, 5'd31, mk(REQ_WRITE, 32'h9, 32'h99), 0, rs(0, 0)},
			'{1, 5'd1, mk(REQ_WRITE, 32'hA, 32'hAA), 0, rs(0, 0)},
			'{0, 0, mk(REQ_LOOKUP, 32'h9, 32'h0), 0, rs(0, 0)},
			'{0, 0, mk(REQ_LOOKUP, 32'hA, 32'h0), 0, rs(0, 0)}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].cfg) write_capacity(dir_rows[i].cap);
			send(dir_rows[i].req, dir_rows[i].known, dir_rows[i].rsp, 1);
		end

		for (phase = 0; phase < 8; phase++) begin
			case (phase)
				0: write_capacity(5'd16);
				1: write_capacity(5'd1);
				2: write_capacity(5'd4);
				3: write_capacity(5'd0);
				4: write_capacity(5'd31);
				5: write_capacity(5'd8);
				6: write_capacity(5'd3);
				default: write_capacity(5'd16);
			endcase
			// random key pool of 2 to 24 keys per phase gives a mix of hits and evictions
			pool = $urandom_range(2, 24);
			for (i = 0; i < 24; i++) keys[i] = $urandom;
			if (phase == 2) long_hold_req = 1;
			for (i = 0; i < 170; i++) begin
				if ($urandom_range(0, 9) == 0)
					r = mk(1'($urandom), $urandom, $urandom);
				else
					r = mk(1'($urandom), keys[$urandom_range(0, pool - 1)], $urandom);
				hot = (phase == 2 && i < 40) || ($urandom_range(0, 4) == 0);
				send(r, 0, '0, !hot);
				if (i == 85 && phase == 5) begin
					in_valid <= 1'b0;
					while (pending_rsp.size() != 0) @(posedge clk);
				end
			end
		end

		in_valid <= 1'b0;
		stim_done = 1;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("covered %0d requests, %0d results (%0d hits), capacities 0 to 31",
			accepted, answered, hits);
		$display("receiver long hold lasted %0d cycles with the sender still offering",
			hold_cycles);
		if (errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

/* lru_key_value_cache.f */
+incdir+rtl/core
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_datapath.sv
rtl/core/lkvc_ctrl.sv
rtl/core/lru_key_value_cache.sv
bench/lru_key_value_cache_tb.sv
